// ----- rtl/aee_pkg.sv -----
// Package for the ADSR envelope with echo tail.
// Holds the item structs, the register map, status bit masks and the shared unit's request type.
// No dependencies; every other file in rtl imports it.
package aee_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Status bits of the voice.
  localparam logic [7:0] ST_START  = 8'h80;
  localparam logic [7:0] ST_REL    = 8'h40;
  localparam logic [7:0] ST_LOOP   = 8'h10;
  localparam logic [7:0] ST_ECHO   = 8'h04;
  localparam logic [7:0] ST_ACT    = 8'hC7;
  localparam logic [7:0] ST_ATTACK = 8'h03;
  localparam logic [7:0] ST_NONE   = 8'h00;

  localparam logic [1:0] SUB_DECAY  = 2'd2;
  localparam logic [1:0] SUB_ATTACK = 2'd3;

  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  // Phase codes shown on the result item.
  localparam logic [2:0] PH_OFF     = 3'd0;
  localparam logic [2:0] PH_SUSTAIN = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_ATTACK  = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;
  localparam logic [2:0] PH_ECHO    = 3'd5;

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_ECHO    = 3'd4,
    REG_MASTER  = 3'd5,
    REG_LEFT    = 3'd6,
    REG_RIGHT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] attack_rate;
    logic [7:0] decay_rate;
    logic [7:0] sustain_level;
    logic [7:0] release_rate;
    logic [7:0] echo_level;
    logic [3:0] master_volume;
    logic [7:0] left_volume;
    logic [7:0] right_volume;
  } cfg_t;

  typedef struct packed {
    logic key_on;
    logic key_off;
    logic loop_sample;
  } tick_t;

  typedef struct packed {
    logic       playing;
    logic [7:0] level;
    logic [2:0] phase;
    logic       restart_sample;
    logic       looping;
    logic [7:0] left_gain;
    logic [7:0] right_gain;
  } env_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_ADD = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

endpackage

// ----- rtl/aee_regs.sv -----
// APB-style register file for the envelope settings.
// Depends on aee_pkg for the register map and the cfg_t struct.
module aee_regs
  import aee_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_rate   <= 8'd255;
      cfg.decay_rate    <= 8'd0;
      cfg.sustain_level <= 8'd255;
      cfg.release_rate  <= 8'd0;
      cfg.echo_level    <= 8'd0;
      cfg.master_volume <= 4'd15;
      cfg.left_volume   <= 8'd255;
      cfg.right_volume  <= 8'd255;
    end else if (wr) begin
      unique case (idx)
        REG_ATTACK:  cfg.attack_rate   <= pwdata[7:0];
        REG_DECAY:   cfg.decay_rate    <= pwdata[7:0];
        REG_SUSTAIN: cfg.sustain_level <= pwdata[7:0];
        REG_RELEASE: cfg.release_rate  <= pwdata[7:0];
        REG_ECHO:    cfg.echo_level    <= pwdata[7:0];
        REG_MASTER:  cfg.master_volume <= pwdata[3:0];
        REG_LEFT:    cfg.left_volume   <= pwdata[7:0];
        REG_RIGHT:   cfg.right_volume  <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ATTACK:  prdata[7:0] = cfg.attack_rate;
      REG_DECAY:   prdata[7:0] = cfg.decay_rate;
      REG_SUSTAIN: prdata[7:0] = cfg.sustain_level;
      REG_RELEASE: prdata[7:0] = cfg.release_rate;
      REG_ECHO:    prdata[7:0] = cfg.echo_level;
      REG_MASTER:  prdata[3:0] = cfg.master_volume;
      REG_LEFT:    prdata[7:0] = cfg.left_volume;
      REG_RIGHT:   prdata[7:0] = cfg.right_volume;
    endcase
  end

endmodule

// ----- rtl/aee_alu.sv -----
// Shared 8 by 8 arithmetic unit: one multiplier and one adder behind an operation select.
// Depends on aee_pkg for the request struct.
module aee_alu
  import aee_pkg::*;
(
  input  alu_req_t    req,
  output logic [15:0] res
);

  always_comb begin
    case (req.op)
      OP_ADD:  res = {7'd0, {1'b0, req.a} + {1'b0, req.b}};
      default: res = {8'd0, req.a} * {8'd0, req.b};
    endcase
  end

endmodule

// ----- rtl/aee_seq.sv -----
// Sequencer for one envelope tick: status merge, envelope step, volume and pan products.
// Drives the shared unit in aee_alu; depends on aee_pkg for types and constants.
module aee_seq
  import aee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  tick_t       tick,
  output logic        env_valid,
  input  logic        env_stall,
  output env_t        env,
  output alu_req_t    alu_req,
  input  logic [15:0] alu_res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP  = 6'b000010,
    S_VOL   = 6'b000100,
    S_LEFT  = 6'b001000,
    S_RIGHT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t     state;
  logic [7:0] status;
  logic [7:0] level;
  logic [7:0] echo_cnt;
  logic       loop_r;
  logic       playing;
  logic       restart;
  logic [7:0] vol;
  logic [7:0] left_g;
  logic [7:0] right_g;
  logic [7:0] status_merged;
  logic [7:0] prod_hi;
  logic [2:0] phase_now;
  logic       stop_now;

  assign tick_stall = (state != S_IDLE);
  assign prod_hi    = alu_res[15:8];

  // Key-on replaces the note; key-off only lands on an active voice.
  always_comb begin
    status_merged = tick.key_on ? (ST_START | (tick.loop_sample ? ST_LOOP : ST_NONE)) : status;
    if (tick.key_off && ((status_merged & ST_ACT) != ST_NONE)) begin
      status_merged = status_merged | ST_REL;
    end
  end

  // The envelope step silences the voice: skip the gain products and go straight to the result.
  always_comb begin
    stop_now = 1'b0;
    if ((status & ST_ACT) == ST_NONE) begin
      stop_now = 1'b1;
    end else if ((status & ST_START) != ST_NONE) begin
      stop_now = ((status & ST_REL) != ST_NONE);
    end else if ((status & ST_ECHO) != ST_NONE) begin
      stop_now = (echo_cnt == 8'd1);
    end else if ((status & ST_REL) != ST_NONE) begin
      stop_now = (prod_hi <= echo_cnt) && (echo_cnt == 8'd0);
    end else if (status[1:0] == SUB_DECAY) begin
      stop_now = (cfg.sustain_level == 8'd0) && (prod_hi == 8'd0) && (echo_cnt == 8'd0);
    end
  end

  always_comb begin
    if (!playing) begin
      phase_now = PH_OFF;
    end else if ((status & ST_ECHO) != ST_NONE) begin
      phase_now = PH_ECHO;
    end else if ((status & ST_REL) != ST_NONE) begin
      phase_now = PH_RELEASE;
    end else begin
      phase_now = {1'b0, status[1:0]};
    end
  end

  always_comb begin
    alu_req = '{op: OP_MUL, a: level, b: cfg.decay_rate};
    unique case (state)
      S_STEP: begin
        if ((status & ST_START) != ST_NONE) begin
          alu_req = '{op: OP_ADD, a: 8'd0, b: cfg.attack_rate};
        end else if ((status & ST_REL) != ST_NONE) begin
          alu_req = '{op: OP_MUL, a: level, b: cfg.release_rate};
        end else if (status[1:0] == SUB_ATTACK) begin
          alu_req = '{op: OP_ADD, a: level, b: cfg.attack_rate};
        end
      end
      S_VOL:   alu_req = '{op: OP_MUL, a: level, b: {4'd0, cfg.master_volume} + 8'd1};
      S_LEFT:  alu_req = '{op: OP_MUL, a: cfg.left_volume, b: vol};
      S_RIGHT: alu_req = '{op: OP_MUL, a: cfg.right_volume, b: vol};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= ST_NONE;
      level     <= 8'd0;
      echo_cnt  <= 8'd0;
      env_valid <= 1'b0;
      playing   <= 1'b0;
      restart   <= 1'b0;
    end else begin
      if (env_valid && !env_stall && state != S_DONE) begin
        env_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_valid) begin
            status  <= status_merged;
            loop_r  <= tick.loop_sample;
            restart <= 1'b0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          playing <= !stop_now;
          state   <= stop_now ? S_DONE : S_VOL;
          if ((status & ST_ACT) == ST_NONE) begin
            // An idle voice takes no step.
          end else if ((status & ST_START) != ST_NONE) begin
            if ((status & ST_REL) != ST_NONE) begin
              // Key-off together with key-on stops the note before it starts.
              status <= ST_NONE;
            end else begin
              status   <= ST_ATTACK | (loop_r ? ST_LOOP : ST_NONE);
              restart  <= 1'b1;
              echo_cnt <= cfg.echo_level;
              level    <= alu_res[7:0];
            end
          end else if ((status & ST_ECHO) != ST_NONE) begin
            echo_cnt <= echo_cnt - 8'd1;
            if (echo_cnt == 8'd1) begin
              status <= ST_NONE;
            end
          end else if ((status & ST_REL) != ST_NONE) begin
            level <= prod_hi;
            if (prod_hi <= echo_cnt) begin
              if (echo_cnt == 8'd0) begin
                status <= ST_NONE;
              end else begin
                status <= status | ST_ECHO;
              end
            end
          end else begin
            case (status[1:0])
              SUB_DECAY: begin
                if (cfg.sustain_level == 8'd0 && prod_hi == 8'd0) begin
                  level <= prod_hi;
                  if (echo_cnt == 8'd0) begin
                    status <= ST_NONE;
                  end else begin
                    status <= status | ST_ECHO;
                  end
                end else if (prod_hi <= cfg.sustain_level) begin
                  level  <= cfg.sustain_level;
                  status <= status - 8'd1;
                end else begin
                  level <= prod_hi;
                end
              end
              SUB_ATTACK: begin
                // Only a sum above full scale moves on to decay.
                if (alu_res[8]) begin
                  level  <= LEVEL_MAX;
                  status <= status - 8'd1;
                end else begin
                  level <= alu_res[7:0];
                end
              end
              default: ;
            endcase
          end
        end
        S_VOL: begin
          vol   <= alu_res[11:4];
          state <= S_LEFT;
        end
        S_LEFT: begin
          left_g <= prod_hi;
          state  <= S_RIGHT;
        end
        S_RIGHT: begin
          right_g <= prod_hi;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!env_valid || !env_stall) begin
            env_valid          <= 1'b1;
            env.playing        <= playing;
            env.level          <= level;
            env.phase          <= phase_now;
            env.restart_sample <= restart;
            env.looping        <= playing && ((status & ST_LOOP) != ST_NONE);
            env.left_gain      <= playing ? left_g : 8'd0;
            env.right_gain     <= playing ? right_g : 8'd0;
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/adsr_echo_envelope.sv -----
// One voice's ADSR envelope with an echo tail, advanced by one tick item per frame. Once a tick
// is accepted, the envelope is stepped, then the level is scaled by the master volume and by the
// left and right pan volumes, all on one shared 8 by 8 multiply/add unit, one use per cycle; a
// tick that leaves the voice silent skips the scaling. tick_stall stays high from acceptance until
// the result item is in the output register; a result that waits there holds the block before
// its last cycle. Settings are read and written over the APB-style port and take effect on the
// next tick item.
// Depends on aee_pkg, aee_regs, aee_alu and aee_seq.
module adsr_echo_envelope
  import aee_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  tick_t             tick,
  output logic              env_valid,
  input  logic              env_stall,
  output env_t              env
);

  cfg_t        cfg;
  alu_req_t    alu_req;
  logic [15:0] alu_res;

  aee_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aee_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  aee_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .env_valid  (env_valid),
    .env_stall  (env_stall),
    .env        (env),
    .alu_req    (alu_req),
    .alu_res    (alu_res)
  );

endmodule

// ----- rtl/aee_checker.sv -----
// Port-level checks for the envelope block, bound to the top level.
// Depends on aee_pkg for the item structs and phase codes.
module aee_checker
  import aee_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  tick_valid,
  input logic  tick_stall,
  input logic  env_valid,
  input logic  env_stall,
  input env_t  env
);

  // A tick item keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) |=> tick_stall)
    else $error("block ready right after accepting a tick item");

  // A silent voice shows no gain, no loop and the off phase.
  a_silent_result: assert property (@(posedge clk) disable iff (rst)
    (env_valid && !env.playing) |->
      (env.left_gain == 8'd0 && env.right_gain == 8'd0 && !env.looping && env.phase == PH_OFF))
    else $error("silent item carries gain, loop or phase");

  // A sample restart only comes with a sounding note in attack.
  a_restart_attack: assert property (@(posedge clk) disable iff (rst)
    (env_valid && env.restart_sample) |-> (env.playing && env.phase == PH_ATTACK))
    else $error("restart outside attack");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (env_valid && env_stall) |=> (env_valid && $stable(env)))
    else $error("stalled result item changed");

endmodule

bind adsr_echo_envelope aee_checker u_aee_checker (.*);

// ----- tb/envelope_watch.sv -----
`timescale 1ns / 1ps
// Checker for adsr_echo_envelope: follows register writes on the APB-style port and predicts the
// envelope item for every tick item taken, then compares each result item field by field.
// Depends on aee_pkg.
module envelope_watch
  import aee_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              tick_valid,
  input  logic              tick_stall,
  input  tick_t             tick,
  input  logic              env_valid,
  input  logic              env_stall,
  input  env_t              env,
  output int                errors,
  output int                pending,
  output int                checked
);

  localparam cfg_t RESET_REGS = '{attack_rate: LEVEL_MAX, decay_rate: 8'h00,
                                  sustain_level: LEVEL_MAX, release_rate: 8'h00,
                                  echo_level: 8'h00, master_volume: 4'hF,
                                  left_volume: LEVEL_MAX, right_volume: LEVEL_MAX};

  cfg_t       regs;
  logic [7:0] voice_status;
  logic [7:0] voice_level;
  logic [7:0] echo_left;
  env_t       due_envelopes[$];
  env_t       want;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(string what);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] envelope mismatch: %s", $time, what);
    end
  endtask

  task automatic field(string name, logic [7:0] got, logic [7:0] exp_v);
    if (got !== exp_v) begin
      report($sformatf("result %0d %s: got %0d, expected %0d", checked, name, got, exp_v));
    end
  endtask

  function automatic bit has(logic [7:0] mask);
    return (voice_status & mask) != ST_NONE;
  endfunction

  function automatic logic [7:0] fraction(logic [7:0] a, logic [7:0] rate);
    int unsigned p;
    p = (32'(a) * 32'(rate)) >> 8;
    return p[7:0];
  endfunction

  // An overflowing sum pins the level and drops the low status bits from attack to decay.
  function automatic void attack_climb();
    int unsigned sum;
    sum = 32'(voice_level) + 32'(regs.attack_rate);
    if (sum > 32'(LEVEL_MAX)) begin
      voice_level  = LEVEL_MAX;
      voice_status = voice_status - 8'd1;
    end else begin
      voice_level = sum[7:0];
    end
  endfunction

  function automatic bit echo_or_silence();
    if (echo_left == 8'd0) begin
      voice_status = ST_NONE;
      return 1'b0;
    end
    voice_status = voice_status | ST_ECHO;
    return 1'b1;
  endfunction

  function automatic env_t advance_voice(tick_t t);
    env_t        r;
    bit          sounding;
    bit          restart;
    int unsigned scaled;
    r       = '0;
    restart = 1'b0;
    if (t.key_on) begin
      voice_status = t.loop_sample ? (ST_START | ST_LOOP) : ST_START;
    end
    if (t.key_off && has(ST_ACT)) begin
      voice_status = voice_status | ST_REL;
    end

    if (!has(ST_ACT)) begin
      sounding = 1'b0;
    end else if (has(ST_START)) begin
      if (has(ST_REL)) begin
        voice_status = ST_NONE;
        sounding     = 1'b0;
      end else begin
        voice_status = ST_ATTACK;
        restart      = 1'b1;
        voice_level  = 8'd0;
        echo_left    = regs.echo_level;
        attack_climb();
        sounding = 1'b1;
      end
    end else if (has(ST_ECHO)) begin
      echo_left = echo_left - 8'd1;
      if (echo_left == 8'd0) begin
        voice_status = ST_NONE;
        sounding     = 1'b0;
      end else begin
        sounding = 1'b1;
      end
    end else if (has(ST_REL)) begin
      voice_level = fraction(voice_level, regs.release_rate);
      if (voice_level > echo_left) begin
        sounding = 1'b1;
      end else begin
        sounding = echo_or_silence();
      end
    end else begin
      sounding = 1'b1;
      case (voice_status[1:0])
        SUB_DECAY: begin
          voice_level = fraction(voice_level, regs.decay_rate);
          if (regs.sustain_level == 8'd0 && voice_level == 8'd0) begin
            sounding = echo_or_silence();
          end else if (voice_level <= regs.sustain_level) begin
            voice_level  = regs.sustain_level;
            voice_status = voice_status - 8'd1;
          end
        end
        SUB_ATTACK: attack_climb();
        default: ;
      endcase
    end

    if (restart) begin
      voice_status = (voice_status & ~ST_LOOP) | (t.loop_sample ? ST_LOOP : ST_NONE);
    end

    r.playing        = sounding;
    r.level          = voice_level;
    r.restart_sample = restart;
    if (sounding) begin
      scaled       = (32'(voice_level) * (32'(regs.master_volume) + 32'd1)) >> 4;
      r.left_gain  = fraction(regs.left_volume, scaled[7:0]);
      r.right_gain = fraction(regs.right_volume, scaled[7:0]);
      r.looping    = has(ST_LOOP);
      if (has(ST_ECHO)) begin
        r.phase = PH_ECHO;
      end else if (has(ST_REL)) begin
        r.phase = PH_RELEASE;
      end else begin
        // The two low status bits are the sustain, decay and attack phase codes.
        r.phase = {1'b0, voice_status[1:0]};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs         = RESET_REGS;
      voice_status = ST_NONE;
      voice_level  = 8'd0;
      echo_left    = 8'd0;
      due_envelopes.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_ATTACK:  regs.attack_rate   = pwdata[7:0];
          REG_DECAY:   regs.decay_rate    = pwdata[7:0];
          REG_SUSTAIN: regs.sustain_level = pwdata[7:0];
          REG_RELEASE: regs.release_rate  = pwdata[7:0];
          REG_ECHO:    regs.echo_level    = pwdata[7:0];
          REG_MASTER:  regs.master_volume = pwdata[3:0];
          REG_LEFT:    regs.left_volume   = pwdata[7:0];
          REG_RIGHT:   regs.right_volume  = pwdata[7:0];
          default: ;
        endcase
      end
      // A result cannot belong to the tick taken at this same edge, so check before predicting.
      if (env_valid && !env_stall) begin
        if (due_envelopes.size() == 0) begin
          report("result item arrived with nothing expected");
        end else begin
          want = due_envelopes.pop_front();
          field("playing", env.playing, want.playing);
          field("level", env.level, want.level);
          field("phase", env.phase, want.phase);
          field("restart_sample", env.restart_sample, want.restart_sample);
          field("looping", env.looping, want.looping);
          field("left_gain", env.left_gain, want.left_gain);
          field("right_gain", env.right_gain, want.right_gain);
        end
        checked++;
      end
      if (tick_valid && !tick_stall) begin
        due_envelopes.push_back(advance_voice(tick));
      end
      pending = due_envelopes.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the adsr_echo_envelope testbench: clock, reset, register programming, tick stimulus
// and random stalls on the result side; the verdict comes from envelope_watch.
// Depends on aee_pkg, envelope_watch and the RTL of adsr_echo_envelope.
module tb_top;
  import aee_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS  = 40;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              tick_valid = 1'b0;
  logic              tick_stall;
  tick_t             tick       = '0;
  logic              env_valid;
  logic              env_stall  = 1'b0;
  env_t              env;

  int errors;
  int pending;
  int checked;
  int cycles       = 0;
  int sent         = 0;
  int settings     = 0;
  int phase_items  = 0;
  int random_items = 0;
  int stall_run    = 0;
  int phase_no     = 0;
  bit calm         = 1'b1;

  adsr_echo_envelope dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .tick_valid, .tick_stall, .tick, .env_valid, .env_stall, .env
  );

  envelope_watch watch (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .tick_valid, .tick_stall, .tick, .env_valid, .env_stall, .env,
    .errors, .pending, .checked
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    if (rst || calm) begin
      env_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      env_stall <= 1'b1;
    end else begin
      env_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        stall_run = pick_gap();
      end
    end
  end

  function automatic tick_t mk_tick(bit on, bit off, bit looped);
    return '{key_on: on, key_off: off, loop_sample: looped};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return LEVEL_MAX;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    c.attack_rate   = ($urandom_range(0, 2) == 0) ? pick_byte() : 8'($urandom_range(1, 80));
    c.decay_rate    = pick_byte();
    c.sustain_level = pick_byte();
    c.release_rate  = pick_byte();
    c.echo_level    = ($urandom_range(0, 3) == 0) ? pick_byte() : 8'($urandom_range(0, 12));
    c.master_volume = 4'($urandom_range(0, 15));
    c.left_volume   = pick_byte();
    c.right_volume  = pick_byte();
    return c;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Junk in the unused upper bits must not matter.
    pwdata  <= {24'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_setting(cfg_t c);
    write_reg(REG_ATTACK, c.attack_rate);
    write_reg(REG_DECAY, c.decay_rate);
    write_reg(REG_SUSTAIN, c.sustain_level);
    write_reg(REG_RELEASE, c.release_rate);
    write_reg(REG_ECHO, c.echo_level);
    write_reg(REG_MASTER, {4'($urandom()), c.master_volume});
    write_reg(REG_LEFT, c.left_volume);
    write_reg(REG_RIGHT, c.right_volume);
    settings++;
  endtask

  task automatic send_tick(tick_t t);
    @(negedge clk);
    tick       <= t;
    tick_valid <= 1'b1;
    do @(posedge clk); while (tick_stall);
    sent++;
    if (!calm && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      tick_valid <= 1'b0;
      repeat (pick_gap() - 1) @(negedge clk);
    end
  endtask

  // Hold the sender until every result has come back and the block has had time to go idle.
  task automatic settle();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // A well-formed note: key-on, some held ticks, key-off, then the release and echo tail.
  task automatic play_note();
    int hold;
    int tail;
    hold = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    tail = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    send_tick(mk_tick(1'b1, 1'b0, 1'($urandom())));
    repeat (hold) send_tick(mk_tick(1'b0, 1'b0, 1'($urandom())));
    send_tick(mk_tick(1'b0, 1'b1, 1'($urandom())));
    repeat (tail) send_tick(mk_tick(1'b0, $urandom_range(0, 4) == 0, 1'($urandom())));
    phase_items += hold + tail + 2;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: key-off while off, key-on with key-off, attack summing to exactly 255,
    // a full-scale decay to sustain, and a release that stops with no echo.
    send_tick(mk_tick(1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b1));
    send_tick(mk_tick(1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0));
    settle();

    // Zero sustain leads decay into echo; a key-off during echo changes nothing; then a
    // release held above the echo floor with a repeated key-off, cut short by a new key-on.
    load_setting('{attack_rate: 8'h60, decay_rate: 8'h40, sustain_level: 8'h00,
                   release_rate: 8'h80, echo_level: 8'h04, master_volume: 4'h0,
                   left_volume: 8'h80, right_volume: LEVEL_MAX});
    send_tick(mk_tick(1'b1, 1'b0, 1'b0));
    repeat (6) send_tick(mk_tick(1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0));
    repeat (3) send_tick(mk_tick(1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 1'b1));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 1'b0));

    while (random_items < RANDOM_ITEMS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 0) begin
        load_setting('0);
      end else if (phase_no == 1) begin
        load_setting('1);
      end else begin
        load_setting(random_setting());
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          send_tick(tick_t'(3'($urandom_range(0, 7))));
          phase_items++;
        end else begin
          play_note();
        end
      end
      random_items += phase_items;
      phase_no++;
    end
    settle();

    $display("summary: %0d tick items under %0d register settings, %0d results compared",
             sent, settings, checked);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- adsr_echo_envelope.f -----
rtl/aee_pkg.sv
rtl/aee_regs.sv
rtl/aee_alu.sv
rtl/aee_seq.sv
rtl/adsr_echo_envelope.sv
rtl/aee_checker.sv
tb/envelope_watch.sv
tb/tb_top.sv
